/* rtl/rpis_pkg.sv */
package rpis_pkg;

    // Fixed field widths of the streaming and configuration ports.
    localparam int OP_W   = 2;
    localparam int SLOT_W = 6;
    localparam int RANK_W = 6;
    localparam int CFG_W  = 7;

    // Pool size after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Result status codes.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Operation carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SORT   = 2'd1,
        OP_INSERT = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // What the scan wave does as it passes through a cell.
    typedef enum logic [1:0] {
        CM_IDLE   = 2'd0,
        CM_INSERT = 2'd1,
        CM_READ   = 2'd2,
        CM_SORT   = 2'd3
    } cell_mode_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        cell_mode_t mode;
        logic       load_we;
        logic       ins_we;
        logic       swap_we;
    } cell_ctrl_t;

    // Flags carried by the scan wave from cell to cell.
    typedef struct packed {
        logic found;
        logic reject;
    } wave_flags_t;

endpackage

/* rtl/rpis_cell.sv */
module rpis_cell
    import rpis_pkg::*;
#(
    parameter int POOL_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int ID_WIDTH    = 16,
    parameter int CELL_INDEX  = 0
)
(
    input  logic                                 clk,
    input  cell_ctrl_t                           ctrl,
    input  logic [SLOT_W-1:0]                    slot,
    input  logic [$clog2(POOL_DEPTH+1)-1:0]      active_cnt,
    input  logic [$clog2(POOL_DEPTH)-1:0]        pass_idx,
    input  logic [$clog2(POOL_DEPTH)-1:0]        target_idx,
    input  logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    new_ent,
    input  logic signed [VALUE_WIDTH:0]          new_key,
    input  logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    swap_a,
    input  logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    swap_b,
    input  logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    left_ent,
    input  wave_flags_t                          wave_flags_in,
    input  logic [$clog2(POOL_DEPTH)-1:0]        wave_idx_in,
    input  logic signed [VALUE_WIDTH:0]          wave_key_in,
    input  logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    wave_a_in,
    input  logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    wave_b_in,
    output logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    ent,
    output wave_flags_t                          wave_flags_out,
    output logic [$clog2(POOL_DEPTH)-1:0]        wave_idx_out,
    output logic signed [VALUE_WIDTH:0]          wave_key_out,
    output logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    wave_a_out,
    output logic [2*VALUE_WIDTH+ID_WIDTH-1:0]    wave_b_out
);

    localparam int KEY_W = VALUE_WIDTH + 1;
    localparam int ENT_W = 2 * VALUE_WIDTH + ID_WIDTH;
    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam logic [31:0] MY_POS = 32'(CELL_INDEX);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    // Stored entry {id, repro worth, worth} and its cached key.
    logic [ENT_W-1:0]        ent_reg;
    logic [ENT_W-1:0]        ent_next;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    // Scan wave stage.
    wave_flags_t             wave_flags_reg;
    wave_flags_t             wave_flags_next;
    logic [IDX_W-1:0]        wave_idx_reg;
    logic [IDX_W-1:0]        wave_idx_next;
    logic signed [KEY_W-1:0] wave_key_reg;
    logic signed [KEY_W-1:0] wave_key_next;
    logic [ENT_W-1:0]        wave_a_reg;
    logic [ENT_W-1:0]        wave_a_next;
    logic [ENT_W-1:0]        wave_b_reg;
    logic [ENT_W-1:0]        wave_b_next;

    logic                          slot_hit;
    logic                          is_active;
    logic                          is_last;
    logic                          is_pass;
    logic                          after_pass;
    logic                          is_target;
    logic                          after_target;
    logic                          key_hit;
    logic signed [VALUE_WIDTH-1:0] own_worth;
    logic signed [VALUE_WIDTH-1:0] new_worth;
    logic signed [VALUE_WIDTH-1:0] worth_next;
    logic signed [VALUE_WIDTH-1:0] repro_next;

    // Position of this cell against the broadcast indexes.
    assign slot_hit     = (32'(slot) == MY_POS);
    assign is_active    = (MY_POS < 32'(active_cnt));
    assign is_last      = ((MY_POS + 32'd1) == 32'(active_cnt));
    assign is_pass      = (32'(pass_idx) == MY_POS);
    assign after_pass   = (MY_POS > 32'(pass_idx));
    assign is_target    = (32'(target_idx) == MY_POS);
    assign after_target = (MY_POS > 32'(target_idx));

    assign own_worth = ent_reg[VALUE_WIDTH-1:0];
    assign new_worth = new_ent[VALUE_WIDTH-1:0];
    assign key_hit   = is_active && !wave_flags_in.found && (key_reg >= new_key);

    // The wave picks up this cell's contribution and moves on next cycle.
    always_comb
    begin
        wave_flags_next = wave_flags_in;
        wave_idx_next   = wave_idx_in;
        wave_key_next   = wave_key_in;
        wave_a_next     = wave_a_in;
        wave_b_next     = wave_b_in;
        case (ctrl.mode)
            CM_INSERT:
            begin
                // First entry whose key is not smaller; the last active one otherwise.
                if (key_hit || (is_last && !wave_flags_in.found))
                begin
                    wave_flags_next.found = 1'b1;
                    wave_idx_next         = MY_IDX;
                end
                if (is_last)
                begin
                    wave_flags_next.reject = (new_worth > own_worth);
                end
            end
            CM_READ:
            begin
                if (slot_hit)
                begin
                    wave_a_next = ent_reg;
                end
            end
            CM_SORT:
            begin
                // Start of the pass seeds the minimum; later cells replace it only
                // when strictly smaller, so the first minimum wins.
                if (is_pass)
                begin
                    wave_key_next = key_reg;
                    wave_idx_next = MY_IDX;
                    wave_a_next   = ent_reg;
                    wave_b_next   = ent_reg;
                end
                else if (after_pass && is_active && (key_reg < wave_key_in))
                begin
                    wave_key_next = key_reg;
                    wave_idx_next = MY_IDX;
                    wave_a_next   = ent_reg;
                end
            end
            default:
            begin
                wave_flags_next = wave_flags_in;
            end
        endcase
    end

    // Entry update: load, insert with shift, or swap at the end of a sort pass.
    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.load_we && slot_hit)
        begin
            ent_next = new_ent;
        end
        if (ctrl.ins_we && is_active)
        begin
            if (is_target)
            begin
                ent_next = new_ent;
            end
            else if (after_target)
            begin
                ent_next = left_ent;
            end
        end
        if (ctrl.swap_we)
        begin
            if (is_pass)
            begin
                ent_next = swap_a;
            end
            else if (is_target)
            begin
                ent_next = swap_b;
            end
        end
    end

    // The key is kept alongside the entry so the scan only compares.
    assign worth_next = ent_next[VALUE_WIDTH-1:0];
    assign repro_next = ent_next[2*VALUE_WIDTH-1:VALUE_WIDTH];
    assign key_next   = KEY_W'(worth_next) + KEY_W'(repro_next);

    always_ff @(posedge clk)
    begin
        ent_reg        <= ent_next;
        key_reg        <= key_next;
        wave_flags_reg <= wave_flags_next;
        wave_idx_reg   <= wave_idx_next;
        wave_key_reg   <= wave_key_next;
        wave_a_reg     <= wave_a_next;
        wave_b_reg     <= wave_b_next;
    end

    assign ent            = ent_reg;
    assign wave_flags_out = wave_flags_reg;
    assign wave_idx_out   = wave_idx_reg;
    assign wave_key_out   = wave_key_reg;
    assign wave_a_out     = wave_a_reg;
    assign wave_b_out     = wave_b_reg;

endmodule

/* rtl/ranked_pool_insert_sort_unit.sv */
// Ranked pool with sorted insertion. The pool sits in a row of POOL_DEPTH cells, one entry
// per cell, and every operation that must look at the entries sends a scan wave down the
// row, one cell per clock. One transaction is worked on at a time. A load goes from
// acceptance straight to the commit and result states; a read or an insert first waits in
// the wave state for the wave's trip through all POOL_DEPTH cells, and a sort of n active
// entries repeats wave and commit once for each of its n - 1 passes. A new input is
// taken once the previous result has been moved into the output register. Entries that were
// never loaded read back as unknown data, so load the pool before reading or sorting it.
module ranked_pool_insert_sort_unit
    import rpis_pkg::*;
#(
    parameter int POOL_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int ID_WIDTH    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration: pool size.
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, low bit up: slot_index, item_worth, item_repro_worth, item_id, zero fill.
    input  logic [((SLOT_W+2*VALUE_WIDTH+ID_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: operation.
    input  logic [OP_W-1:0]       s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, low bit up: placed_rank, read_worth, read_repro_worth, read_id, zero fill.
    output logic [((RANK_W+2*VALUE_WIDTH+ID_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser: status.
    output logic [0:0]            m_axis_tuser
);

    localparam int KEY_W       = VALUE_WIDTH + 1;
    localparam int ENT_W       = 2 * VALUE_WIDTH + ID_WIDTH;
    localparam int IDX_W       = $clog2(POOL_DEPTH);
    localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
    localparam int OUT_TDATA_W = ((RANK_W + ENT_W + 7) / 8) * 8;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WAVE   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [CFG_W-1:0]        pool_size_reg;
    op_t                     op_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic [ENT_W-1:0]        new_ent_reg;
    logic signed [KEY_W-1:0] new_key_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [IDX_W-1:0]        pass_reg;
    logic [IDX_W-1:0]        pass_next;
    logic [IDX_W-1:0]        wave_cnt_reg;
    logic [IDX_W-1:0]        wave_cnt_next;
    logic                    res_status_reg;
    logic                    res_status_next;
    logic [RANK_W-1:0]       res_rank_reg;
    logic [RANK_W-1:0]       res_rank_next;
    logic [ENT_W-1:0]        res_data_reg;
    logic [ENT_W-1:0]        res_data_next;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;
    logic                    m_tuser_reg;

    logic                          in_fire;
    logic                          out_free;
    logic signed [VALUE_WIDTH-1:0] in_worth;
    logic signed [VALUE_WIDTH-1:0] in_repro;
    logic [ID_WIDTH-1:0]           in_id;
    cell_ctrl_t                    ctrl;
    logic [31:0]                   rank_wide;

    // Row of cells and the wave links between them.
    logic [ENT_W-1:0]        cell_ent   [POOL_DEPTH];
    wave_flags_t             cell_flags [POOL_DEPTH];
    logic [IDX_W-1:0]        cell_idx   [POOL_DEPTH];
    logic signed [KEY_W-1:0] cell_key   [POOL_DEPTH];
    logic [ENT_W-1:0]        cell_a     [POOL_DEPTH];
    logic [ENT_W-1:0]        cell_b     [POOL_DEPTH];

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;

    // Input field extraction.
    assign in_worth = s_axis_tdata[SLOT_W +: VALUE_WIDTH];
    assign in_repro = s_axis_tdata[SLOT_W+VALUE_WIDTH +: VALUE_WIDTH];
    assign in_id    = s_axis_tdata[SLOT_W+2*VALUE_WIDTH +: ID_WIDTH];

    // Clamp the configured pool size into the range the row supports.
    always_comb
    begin
        if (pool_size_reg < CFG_W'(2))
        begin
            cnt_next = CNT_W'(2);
        end
        else if (32'(pool_size_reg) > 32'(POOL_DEPTH))
        begin
            cnt_next = CNT_W'(POOL_DEPTH);
        end
        else
        begin
            cnt_next = CNT_W'(pool_size_reg);
        end
    end

    assign rank_wide = 32'(cell_idx[POOL_DEPTH-1]);

    // Sequencer: run the wave past the last cell (a load skips it), then commit.
    always_comb
    begin
        state_next      = state_reg;
        pass_next       = pass_reg;
        wave_cnt_next   = wave_cnt_reg;
        res_status_next = res_status_reg;
        res_rank_next   = res_rank_reg;
        res_data_next   = res_data_reg;
        ctrl            = '{mode: CM_IDLE, load_we: 1'b0, ins_we: 1'b0, swap_we: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pass_next     = '0;
                    wave_cnt_next = '0;
                    if (op_t'(s_axis_tuser) == OP_LOAD)
                    begin
                        state_next = S_COMMIT;
                    end
                    else
                    begin
                        state_next = S_WAVE;
                    end
                end
            end
            S_WAVE:
            begin
                unique case (op_reg)
                    OP_INSERT: ctrl.mode = CM_INSERT;
                    OP_READ:   ctrl.mode = CM_READ;
                    OP_SORT:   ctrl.mode = CM_SORT;
                    default:   ctrl.mode = CM_IDLE;
                endcase
                wave_cnt_next = wave_cnt_reg + IDX_W'(1);
                if (wave_cnt_reg == IDX_W'(POOL_DEPTH - 1))
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                res_status_next = STATUS_OK;
                res_rank_next   = '0;
                res_data_next   = '0;
                state_next      = S_RESULT;
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        ctrl.load_we = 1'b1;
                    end
                    OP_READ:
                    begin
                        res_data_next = cell_a[POOL_DEPTH-1];
                    end
                    OP_INSERT:
                    begin
                        if (cell_flags[POOL_DEPTH-1].reject)
                        begin
                            res_status_next = STATUS_REJECT;
                        end
                        else
                        begin
                            ctrl.ins_we   = 1'b1;
                            res_rank_next = rank_wide[RANK_W-1:0];
                        end
                    end
                    OP_SORT:
                    begin
                        // Swap the pass minimum into place; run another pass if one is left.
                        ctrl.swap_we = 1'b1;
                        if ((32'(pass_reg) + 32'd2) < 32'(cnt_reg))
                        begin
                            pass_next     = pass_reg + IDX_W'(1);
                            wave_cnt_next = '0;
                            state_next    = S_WAVE;
                        end
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pool_size_reg <= CFG_RESET;
            pass_reg      <= '0;
            wave_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pass_reg     <= pass_next;
            wave_cnt_reg <= wave_cnt_next;
            if (cfg_we)
            begin
                pool_size_reg <= cfg_wdata;
            end
            if ((state_reg == S_RESULT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Transaction and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= op_t'(s_axis_tuser);
            slot_reg    <= s_axis_tdata[SLOT_W-1:0];
            new_ent_reg <= {in_id, in_repro, in_worth};
            new_key_reg <= KEY_W'(in_worth) + KEY_W'(in_repro);
            cnt_reg     <= cnt_next;
        end
        res_status_reg <= res_status_next;
        res_rank_reg   <= res_rank_next;
        res_data_reg   <= res_data_next;
        if ((state_reg == S_RESULT) && out_free)
        begin
            m_tdata_reg <= OUT_TDATA_W'({res_data_reg, res_rank_reg});
            m_tuser_reg <= res_status_reg;
        end
    end

    // The row of cells.
    for (genvar g = 0; g < POOL_DEPTH; g++)
    begin : g_cell
        logic [ENT_W-1:0]        left_ent;
        wave_flags_t             flags_in;
        logic [IDX_W-1:0]        idx_in;
        logic signed [KEY_W-1:0] key_in;
        logic [ENT_W-1:0]        a_in;
        logic [ENT_W-1:0]        b_in;

        if (g == 0)
        begin : g_head
            assign left_ent = '0;
            assign flags_in = '{found: 1'b0, reject: 1'b0};
            assign idx_in   = '0;
            assign key_in   = '0;
            assign a_in     = '0;
            assign b_in     = '0;
        end
        else
        begin : g_link
            assign left_ent = cell_ent[g-1];
            assign flags_in = cell_flags[g-1];
            assign idx_in   = cell_idx[g-1];
            assign key_in   = cell_key[g-1];
            assign a_in     = cell_a[g-1];
            assign b_in     = cell_b[g-1];
        end

        rpis_cell #(
            .POOL_DEPTH  (POOL_DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .ID_WIDTH    (ID_WIDTH),
            .CELL_INDEX  (g)
        ) u_cell (
            .clk            (clk),
            .ctrl           (ctrl),
            .slot           (slot_reg),
            .active_cnt     (cnt_reg),
            .pass_idx       (pass_reg),
            .target_idx     (cell_idx[POOL_DEPTH-1]),
            .new_ent        (new_ent_reg),
            .new_key        (new_key_reg),
            .swap_a         (cell_a[POOL_DEPTH-1]),
            .swap_b         (cell_b[POOL_DEPTH-1]),
            .left_ent       (left_ent),
            .wave_flags_in  (flags_in),
            .wave_idx_in    (idx_in),
            .wave_key_in    (key_in),
            .wave_a_in      (a_in),
            .wave_b_in      (b_in),
            .ent            (cell_ent[g]),
            .wave_flags_out (cell_flags[g]),
            .wave_idx_out   (cell_idx[g]),
            .wave_key_out   (cell_key[g]),
            .wave_a_out     (cell_a[g]),
            .wave_b_out     (cell_b[g])
        );
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

endmodule

/* rtl/rpis_checker.sv */
module rpis_checker
    import rpis_pkg::*;
#(
    parameter int POOL_DEPTH  = 64,
    parameter int VALUE_WIDTH = 32,
    parameter int ID_WIDTH    = 16
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [((SLOT_W+2*VALUE_WIDTH+ID_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic [OP_W-1:0]       s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [((RANK_W+2*VALUE_WIDTH+ID_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [0:0]            m_axis_tuser
);

    localparam int ENT_W = 2 * VALUE_WIDTH + ID_WIDTH;

    logic in_fire;
    op_t  op_reg;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Operation of the transaction in flight, seen at the input port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_LOAD;
        end
        else if (in_fire)
        begin
            op_reg <= op_t'(s_axis_tuser);
        end
    end

    // Only one transaction is in progress at a time.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input accepted while a transaction is in progress");

    // A result waiting for the sink keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output result changed while stalled");

    // A rejected newcomer reports no rank.
    a_reject_rank: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == STATUS_REJECT) |->
            (m_axis_tdata[RANK_W-1:0] == '0))
        else $error("rejected insert reports a rank");

    // Entry data appears only on reads; rank and status only on inserts. While the
    // input is ready, the result shown belongs to the last accepted transaction.
    a_field_use: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && s_axis_tready |->
            ((op_reg == OP_READ) || (m_axis_tdata[RANK_W +: ENT_W] == '0)) &&
            ((op_reg == OP_INSERT) ||
             ((m_axis_tdata[RANK_W-1:0] == '0) && (m_axis_tuser[0] == STATUS_OK))))
        else $error("result carries fields its operation does not produce");

endmodule

bind ranked_pool_insert_sort_unit rpis_checker #(
    .POOL_DEPTH  (POOL_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ID_WIDTH    (ID_WIDTH)
) u_rpis_checker (.*);

/* tb/ranked_pool_insert_sort_unit_tb.sv */
module ranked_pool_insert_sort_unit_tb;
    import rpis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam int VW    = 32;
    localparam int IW    = 16;
    localparam int IN_DATA_W  = ((SLOT_W + 2 * VW + IW + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RANK_W + 2 * VW + IW + 7) / 8) * 8;
    localparam longint CYCLE_LIMIT = 2_500_000;
    localparam logic signed [VW-1:0] WORTH_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VW-1:0] WORTH_MIN = 32'sh8000_0000;

    // One pool operation as it travels on the input stream.
    typedef struct {
        op_t                    op;
        logic [SLOT_W-1:0]      slot;
        logic signed [VW-1:0]   worth;
        logic signed [VW-1:0]   repro;
        logic [IW-1:0]          member;
    } pool_op_t;

    // One result as it leaves on the output stream.
    typedef struct {
        logic                   status;
        logic [RANK_W-1:0]      rank;
        logic [VW-1:0]          rd_worth;
        logic [VW-1:0]          rd_repro;
        logic [IW-1:0]          rd_member;
    } pool_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    // Shadow copy of the pool and its size register.
    logic signed [VW-1:0]   pool_worth [DEPTH];
    logic signed [VW-1:0]   pool_repro [DEPTH];
    logic [IW-1:0]          pool_member [DEPTH];
    logic [CFG_W-1:0]       pool_size_shadow;

    pool_op_t               pending_ops [$];
    pool_result_t           awaited_results [$];
    int                     items_queued = 0;
    int                     results_seen = 0;
    int                     mismatch_count = 0;
    int                     idle_pct = 30;
    int                     send_gap = 0;
    int                     recv_gap = 0;
    logic                   in_taken = 1'b0;
    longint                 cycle_count = 0;

    ranked_pool_insert_sort_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Sizes below two act as two, sizes above the depth act as the depth.
    function automatic int active_entries();
        if (pool_size_shadow < 2)
            return 2;
        if (pool_size_shadow > DEPTH)
            return DEPTH;
        return int'(pool_size_shadow);
    endfunction

    // The sort key is formed exactly, in a longint wider than the values.
    function automatic longint entry_key(int i);
        return longint'(pool_worth[i]) + longint'(pool_repro[i]);
    endfunction

    function automatic void swap_entries(int a, int b);
        logic signed [VW-1:0] w;
        logic signed [VW-1:0] r;
        logic [IW-1:0]        m;
        w = pool_worth[a];
        r = pool_repro[a];
        m = pool_member[a];
        pool_worth[a]  = pool_worth[b];
        pool_repro[a]  = pool_repro[b];
        pool_member[a] = pool_member[b];
        pool_worth[b]  = w;
        pool_repro[b]  = r;
        pool_member[b] = m;
    endfunction

    // Selection sort; each pass takes the first entry with the strictly smallest key.
    function automatic void order_shadow(int n);
        int best;
        for (int i = 0; i + 1 < n; i++)
        begin
            best = i;
            for (int j = i + 1; j < n; j++)
            begin
                if (entry_key(j) < entry_key(best))
                    best = j;
            end
            if (best != i)
                swap_entries(i, best);
        end
    endfunction

    // Applies one operation to the shadow pool and returns the result it should give.
    function automatic pool_result_t pool_apply(pool_op_t itm);
        pool_result_t res;
        int           n;
        int           rank;
        longint       new_key;
        res.status    = STATUS_OK;
        res.rank      = '0;
        res.rd_worth  = '0;
        res.rd_repro  = '0;
        res.rd_member = '0;
        n = active_entries();
        case (itm.op)
            OP_LOAD:
            begin
                pool_worth[itm.slot]  = itm.worth;
                pool_repro[itm.slot]  = itm.repro;
                pool_member[itm.slot] = itm.member;
            end
            OP_SORT:
            begin
                order_shadow(n);
            end
            OP_INSERT:
            begin
                if (itm.worth > pool_worth[n - 1])
                begin
                    res.status = STATUS_REJECT;
                end
                else
                begin
                    new_key = longint'(itm.worth) + longint'(itm.repro);
                    rank = n - 1;
                    // Scanning from the back leaves the first position with a key not smaller.
                    for (int i = n - 1; i >= 0; i--)
                    begin
                        if (entry_key(i) >= new_key)
                            rank = i;
                    end
                    for (int i = n - 1; i > rank; i--)
                    begin
                        pool_worth[i]  = pool_worth[i - 1];
                        pool_repro[i]  = pool_repro[i - 1];
                        pool_member[i] = pool_member[i - 1];
                    end
                    pool_worth[rank]  = itm.worth;
                    pool_repro[rank]  = itm.repro;
                    pool_member[rank] = itm.member;
                    res.rank = RANK_W'(rank);
                end
            end
            default:
            begin
                res.rd_worth  = pool_worth[itm.slot];
                res.rd_repro  = pool_repro[itm.slot];
                res.rd_member = pool_member[itm.slot];
            end
        endcase
        return res;
    endfunction

    // Values mix extremes, small numbers that give equal keys, and full-range noise.
    function automatic logic signed [VW-1:0] random_worth();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            case ($urandom_range(0, 3))
                0: return WORTH_MAX;
                1: return WORTH_MIN;
                2: return '0;
                default: return '1;
            endcase
        end
        if (sel <= 4)
            return VW'($signed($urandom_range(0, 16)) - 8);
        if (sel <= 6)
            return VW'($signed($urandom_range(0, 65535)) - 32768);
        return $urandom;
    endfunction

    function automatic pool_op_t make_op(op_t op, int slot, logic signed [VW-1:0] w,
                                         logic signed [VW-1:0] r, int member);
        pool_op_t itm;
        itm.op     = op;
        itm.slot   = SLOT_W'(slot);
        itm.worth  = w;
        itm.repro  = r;
        itm.member = IW'(member);
        return itm;
    endfunction

    function automatic pool_op_t random_pool_op();
        int   pick;
        op_t  op;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            op = OP_INSERT;
        else if (pick < 80)
            op = OP_READ;
        else if (pick < 96)
            op = OP_LOAD;
        else
            op = OP_SORT;
        return make_op(op, $urandom_range(0, DEPTH - 1), random_worth(), random_worth(),
                       $urandom_range(0, 65535));
    endfunction

    task automatic queue_op(pool_op_t itm);
        pending_ops.push_back(itm);
        items_queued++;
    endtask

    task automatic wait_for_pool_idle();
        while (results_seen < items_queued)
            @(negedge clk);
    endtask

    // The size register is only written once every result has come back.
    task automatic write_pool_size(int value);
        wait_for_pool_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(value);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic report_field(string name, logic [VW-1:0] exp_v, logic [VW-1:0] act_v);
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, exp_v, act_v);
    endtask

    // Input driver: holds a transaction until it is taken, with random gaps between.
    always @(negedge clk)
    begin : input_driver
        pool_op_t itm;
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_taken)
            begin
                // Hold the current transaction.
            end
            else if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_gap = $urandom_range(0, 10);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                itm = pending_ops.pop_front();
                s_axis_tdata  <= {2'b00, itm.member, itm.repro, itm.worth, itm.slot};
                s_axis_tuser  <= itm.op;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output back-pressure in random bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                recv_gap = $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: tracks configuration and input transactions, checks every result.
    always @(posedge clk)
    begin : result_check
        pool_op_t     itm;
        pool_result_t exp_r;
        pool_result_t act_r;
        logic         bad;
        if (!rst_n)
        begin
            pool_size_shadow = CFG_RESET;
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (cfg_we)
                pool_size_shadow = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
            begin
                itm.op     = op_t'(s_axis_tuser);
                itm.slot   = s_axis_tdata[SLOT_W-1:0];
                itm.worth  = s_axis_tdata[SLOT_W +: VW];
                itm.repro  = s_axis_tdata[SLOT_W + VW +: VW];
                itm.member = s_axis_tdata[SLOT_W + 2 * VW +: IW];
                awaited_results.push_back(pool_apply(itm));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                act_r.status    = m_axis_tuser[0];
                act_r.rank      = m_axis_tdata[RANK_W-1:0];
                act_r.rd_worth  = m_axis_tdata[RANK_W +: VW];
                act_r.rd_repro  = m_axis_tdata[RANK_W + VW +: VW];
                act_r.rd_member = m_axis_tdata[RANK_W + 2 * VW +: IW];
                if (awaited_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result with nothing pending");
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    bad = (exp_r.status != act_r.status) || (exp_r.rank != act_r.rank)
                       || (exp_r.rd_worth != act_r.rd_worth)
                       || (exp_r.rd_repro != act_r.rd_repro)
                       || (exp_r.rd_member != act_r.rd_member);
                    if (bad)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            if (exp_r.status != act_r.status)
                                report_field("status", VW'(exp_r.status),
                                             VW'(act_r.status));
                            if (exp_r.rank != act_r.rank)
                                report_field("placed_rank", VW'(exp_r.rank),
                                             VW'(act_r.rank));
                            if (exp_r.rd_worth != act_r.rd_worth)
                                report_field("read_worth", exp_r.rd_worth, act_r.rd_worth);
                            if (exp_r.rd_repro != act_r.rd_repro)
                                report_field("read_repro_worth", exp_r.rd_repro,
                                             act_r.rd_repro);
                            if (exp_r.rd_member != act_r.rd_member)
                                report_field("read_id", VW'(exp_r.rd_member),
                                             VW'(act_r.rd_member));
                        end
                    end
                    results_seen++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ranked_pool_insert_sort_unit: mismatch");
            $finish;
        end
    end

    // Stimulus: directed cases on a two-entry pool, a full fill, then random phases.
    initial
    begin : stimulus
        int phase_sizes [$];
        int slots [$];
        int per_phase;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A size of zero acts as two entries.
        write_pool_size(0);
        queue_op(make_op(OP_LOAD, 0, WORTH_MAX, WORTH_MAX, 16'hFFFF));
        queue_op(make_op(OP_LOAD, 1, WORTH_MIN, WORTH_MIN, 0));
        queue_op(make_op(OP_READ, 0, 0, 0, 0));
        queue_op(make_op(OP_READ, 1, 0, 0, 0));
        queue_op(make_op(OP_SORT, 0, 0, 0, 0));
        queue_op(make_op(OP_READ, 0, 0, 0, 0));
        queue_op(make_op(OP_READ, 1, 0, 0, 0));
        // Middle key, then a newcomer worse than the last entry's worth.
        queue_op(make_op(OP_INSERT, 0, WORTH_MIN, WORTH_MAX, 16'h1234));
        queue_op(make_op(OP_INSERT, 0, WORTH_MAX, 0, 16'h5678));
        // Worth equal to the last entry, key equal to an existing key.
        queue_op(make_op(OP_INSERT, 0, WORTH_MIN, WORTH_MAX, 16'h0F0F));
        queue_op(make_op(OP_INSERT, 0, WORTH_MIN, WORTH_MIN, 16'hF0F0));
        // Key larger than every entry lands on the last position.
        queue_op(make_op(OP_INSERT, 0, WORTH_MIN, 5, 16'hAAAA));
        queue_op(make_op(OP_READ, 0, 0, 0, 0));
        queue_op(make_op(OP_READ, 1, 0, 0, 0));
        // Loads and reads beyond the active size reach the stored entry.
        queue_op(make_op(OP_LOAD, DEPTH - 1, WORTH_MAX, WORTH_MIN, 16'h5555));
        queue_op(make_op(OP_READ, DEPTH - 1, 0, 0, 0));
        queue_op(make_op(OP_LOAD, 2, -1, 1, 16'h8001));
        queue_op(make_op(OP_READ, 2, 0, 0, 0));

        // Fill every slot in random order so no later operation meets an unwritten entry.
        write_pool_size(DEPTH);
        for (int i = 0; i < DEPTH; i++)
            slots.push_back(i);
        slots.shuffle();
        foreach (slots[i])
            queue_op(make_op(OP_LOAD, slots[i], random_worth(), random_worth(),
                             $urandom_range(0, 65535)));
        queue_op(make_op(OP_SORT, 0, 0, 0, 0));

        phase_sizes = '{127, 1, 5, 2, 65, 0, 33, $urandom_range(2, 64),
                        $urandom_range(2, 127), 64};
        per_phase = 115;
        foreach (phase_sizes[p])
        begin
            write_pool_size(phase_sizes[p]);
            if (p == phase_sizes.size() - 1)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(0, 3) * 15;
            // Each phase starts from an ordered pool.
            queue_op(make_op(OP_SORT, 0, 0, 0, 0));
            for (int k = 0; k < per_phase; k++)
            begin
                // Halfway through one phase the sender waits for all results.
                if (p == 3 && k == per_phase / 2)
                    wait_for_pool_idle();
                queue_op(random_pool_op());
            end
        end

        wait_for_pool_idle();
        repeat (2 * DEPTH + 20) @(negedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("ranked_pool_insert_sort_unit: match");
        else
            $display("ranked_pool_insert_sort_unit: mismatch");
        $finish;
    end

endmodule
